FILE: rtl/rbc_pkg.sv
// Shared types, constants and codes for the request batch coalescer.
// No dependencies; rbc_front, rbc_back and the top level import this package.
package rbc_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int TAG_W    = 16;
    localparam int BYTES_W  = 24;
    localparam int TIME_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int BCNT_W   = 6;
    localparam int DELAY_W  = 16;
    localparam int QB_W     = BYTES_W + CNT_W;

    // Largest batch and largest drain burst
    localparam int MAX_OUT = 32;
    localparam int NPOP_W  = $clog2(MAX_OUT + 1);

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Register reset values
    localparam logic [BCNT_W-1:0]  BATCH_COUNT_RST = BCNT_W'(5);
    localparam logic [DELAY_W-1:0] BATCH_DELAY_RST = DELAY_W'(20);
    localparam logic [BYTES_W-1:0] BATCH_BYTES_RST = BYTES_W'(500 * 1024);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_BYTES = 2'd2;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_ENQUEUE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SHUTDOWN = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHUTDOWN   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [TAG_W-1:0]   request_tag;
        logic [BYTES_W-1:0] value_bytes;
    } rbc_in_t;

    typedef struct packed {
        logic [TAG_W-1:0]    out_tag;
        logic [POS_W-1:0]    batch_position;
        logic                last_in_batch;
        logic [STATUS_W-1:0] status;
    } rbc_out_t;

    typedef struct packed {
        logic [BCNT_W-1:0]  batch_count;
        logic [DELAY_W-1:0] batch_delay_ms;
        logic [BYTES_W-1:0] batch_max_bytes;
    } rbc_cfg_t;

    typedef enum logic [1:0] {
        OP_ENQUEUE,
        OP_TICK,
        OP_DRAIN
    } rbc_op_t;

    typedef struct packed {
        rbc_op_t            op;
        logic [TAG_W-1:0]   tag;
        logic [BYTES_W-1:0] bytes;
    } rbc_cmd_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [BYTES_W-1:0] bytes;
        logic [TIME_W-1:0]  stamp;
    } rbc_entry_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_REJECT,
        B_READ,
        B_EVAL,
        B_POP
    } rbc_bstate_t;

endpackage

FILE: rtl/rbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/rbc_front.sv
// Front end: accepts requests, decodes the function code and queues commands.
// Depends on rbc_pkg.
module rbc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  rbc_pkg::rbc_in_t req,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output rbc_pkg::rbc_cmd_t cmd
);
    import rbc_pkg::*;

    rbc_cmd_t              q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_reg, wr_next;
    logic [CMDQ_PTR_W-1:0] rd_reg, rd_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;

    logic     push;
    logic     pop;
    logic     known;
    rbc_cmd_t dec;

    // Decode; the unused function code is accepted and dropped
    always_comb
    begin
        dec.tag   = req.request_tag;
        dec.bytes = req.value_bytes;
        dec.op    = OP_ENQUEUE;
        known     = 1'b1;
        unique case (req.func)
            FUNC_ENQUEUE:  dec.op = OP_ENQUEUE;
            FUNC_TICK:     dec.op = OP_TICK;
            FUNC_SHUTDOWN: dec.op = OP_DRAIN;
            default:       known  = 1'b0;
        endcase
    end

    assign req_ready = (cnt_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign push      = req_valid && req_ready && known;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= dec;
        end
    end

endmodule

FILE: rtl/rbc_back.sv
// Back end: request queue, clock and sweep state, flush sequencer, result register.
// Depends on rbc_pkg and rbc_ram.
module rbc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rbc_pkg::rbc_cfg_t cfg,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  rbc_pkg::rbc_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rbc_pkg::rbc_out_t rsp
);
    import rbc_pkg::*;

    rbc_bstate_t         state_reg, state_next;
    rbc_op_t             op_reg, op_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [QB_W-1:0]     qb_reg, qb_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [DELAY_W-1:0]  sweep_reg, sweep_next;
    logic                ended_reg, ended_next;
    logic [NPOP_W-1:0]   npop_reg, npop_next;
    logic [QB_W-1:0]     taken_reg, taken_next;
    logic [TAG_W-1:0]    rej_tag_reg, rej_tag_next;
    logic [STATUS_W-1:0] rej_st_reg, rej_st_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rbc_out_t            rsp_reg, rsp_next;

    logic              ram_we;
    rbc_entry_t        ram_wdata;
    rbc_entry_t        head_entry;
    logic              slot_free;
    logic              full;
    logic [NPOP_W-1:0] cap;
    logic              due;
    logic              sweep_fire;
    logic              go_pop;
    logic [QB_W-1:0]   taken_sum;
    logic [NPOP_W-1:0] npop_inc;
    logic              last;
    logic [TIME_W-1:0] age;

    rbc_ram #(
        .WIDTH ($bits(rbc_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_next),
        .rdata (head_entry)
    );

    assign ram_wdata = '{tag: cmd.tag, bytes: cmd.bytes, stamp: now_reg};
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign full      = (cnt_reg >= CNT_W'(QUEUE_DEPTH));
    assign cmd_ready = (state_reg == B_IDLE);

    // Effective batch cap: zero acts as one, clamp at the burst limit
    always_comb
    begin
        priority if (cfg.batch_count == '0)
            cap = NPOP_W'(1);
        else if (NPOP_W'(cfg.batch_count) > NPOP_W'(MAX_OUT))
            cap = NPOP_W'(MAX_OUT);
        else
            cap = NPOP_W'(cfg.batch_count);
    end

    // Flush condition, valid in B_EVAL where head_entry holds the head
    assign age = now_reg - head_entry.stamp;
    assign due = (NPOP_W'(cnt_reg) >= cap)
              || (qb_reg >= QB_W'(cfg.batch_max_bytes))
              || ((cnt_reg != '0) && (age > TIME_W'(cfg.batch_delay_ms)));
    assign sweep_fire = (sweep_reg <= DELAY_W'(1)) || due;

    always_comb
    begin
        unique case (op_reg)
            OP_ENQUEUE: go_pop = due;
            OP_TICK:    go_pop = sweep_fire;
            OP_DRAIN:   go_pop = 1'b1;
            default:    go_pop = 1'b0;
        endcase
    end

    // End of the current batch, valid in B_POP
    assign taken_sum = taken_reg + QB_W'(head_entry.bytes);
    assign npop_inc  = npop_reg + 1'b1;
    assign last = (cnt_reg == CNT_W'(1))
               || (npop_inc == NPOP_W'(MAX_OUT))
               || ((op_reg != OP_DRAIN)
                   && ((npop_inc >= cap) || (taken_sum >= QB_W'(cfg.batch_max_bytes))));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_ENQUEUE: state_next = (ended_reg || full) ? B_REJECT : B_READ;
                        OP_TICK:    state_next = ended_reg ? B_IDLE : B_READ;
                        OP_DRAIN:   state_next = B_READ;
                        default:    state_next = B_IDLE;
                    endcase
                end
            end
            B_REJECT:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            B_READ:
            begin
                state_next = B_EVAL;
            end
            B_EVAL:
            begin
                state_next = (go_pop && (cnt_reg != '0)) ? B_POP : B_IDLE;
            end
            B_POP:
            begin
                if (slot_free && last)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        op_next        = op_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        qb_next        = qb_reg;
        now_next       = now_reg;
        sweep_next     = sweep_reg;
        ended_next     = ended_reg;
        npop_next      = npop_reg;
        taken_next     = taken_reg;
        rej_tag_next   = rej_tag_reg;
        rej_st_next    = rej_st_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next      = cmd.op;
                    rej_tag_next = cmd.tag;
                    unique case (cmd.op)
                        OP_ENQUEUE:
                        begin
                            priority if (ended_reg)
                                rej_st_next = ST_SHUTDOWN;
                            else if (full)
                                rej_st_next = ST_QUEUE_FULL;
                            else
                            begin
                                ram_we    = 1'b1;
                                tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                            '0 : tail_reg + 1'b1;
                                cnt_next  = cnt_reg + 1'b1;
                                qb_next   = qb_reg + QB_W'(cmd.bytes);
                            end
                        end
                        OP_TICK:
                        begin
                            now_next = now_reg + 1'b1;
                        end
                        OP_DRAIN:
                        begin
                            ended_next = 1'b1;
                        end
                        default:
                        begin
                            op_next = op_reg;
                        end
                    endcase
                end
            end
            B_REJECT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next = '{out_tag: rej_tag_reg, batch_position: '0,
                                 last_in_batch: 1'b1, status: rej_st_reg};
                end
            end
            B_READ:
            begin
                npop_next  = '0;
                taken_next = '0;
            end
            B_EVAL:
            begin
                if (op_reg == OP_TICK)
                begin
                    sweep_next = sweep_fire ? cfg.batch_delay_ms : sweep_reg - 1'b1;
                end
            end
            B_POP:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next = '{out_tag: head_entry.tag,
                                 batch_position: npop_reg[POS_W-1:0],
                                 last_in_batch: last,
                                 status: (op_reg == OP_DRAIN) ? ST_SHUTDOWN : ST_DISPATCHED};
                    head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : head_reg + 1'b1;
                    cnt_next   = cnt_reg - 1'b1;
                    qb_next    = qb_reg - QB_W'(head_entry.bytes);
                    taken_next = taken_sum;
                    npop_next  = npop_inc;
                end
            end
            default:
            begin
                op_next = op_reg;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            op_reg        <= OP_ENQUEUE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            qb_reg        <= '0;
            now_reg       <= '0;
            sweep_reg     <= '0;
            ended_reg     <= 1'b0;
            npop_reg      <= '0;
            taken_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            qb_reg        <= qb_next;
            now_reg       <= now_next;
            sweep_reg     <= sweep_next;
            ended_reg     <= ended_next;
            npop_reg      <= npop_next;
            taken_reg     <= taken_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rej_tag_reg <= rej_tag_next;
        rej_st_reg  <= rej_st_next;
        rsp_reg     <= rsp_next;
    end

    // Queue occupancy never exceeds the storage
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // An empty queue holds no bytes
    a_empty_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (qb_reg == '0))
        else $error("byte total nonzero on empty queue");

    // The flush sequencer only runs on a non-empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_POP) |-> (cnt_reg != '0))
        else $error("pop from empty queue");

    // Each emitted entry removes exactly one queue entry
    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == B_POP) && slot_free) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("pop did not decrement count");

endmodule

FILE: rtl/request_batch_coalescer_top.sv
// Top level of the request batch coalescer: configuration registers and wiring.
// Depends on rbc_pkg, rbc_front, rbc_back (and through it rbc_ram).

// Request batch coalescer. Requests (func enqueue) are queued with their tag,
// byte size and the current millisecond count; a batch of results leaves when
// the queue reaches batch_count entries, the byte total reaches batch_max_bytes,
// or the head entry is older than batch_delay_ms. A tick (func 1) advances the
// clock and runs the periodic sweep; shutdown (func 2) drains up to 32 queued
// entries with status 1 and turns later requests away. Each result carries its
// position in the batch and a last flag on the final result of the request
// that caused it. Timing: the front end decodes each request into a two-entry
// command queue, so up to two requests are taken while the back end is busy.
// The back end takes a command in B_IDLE, waits in B_READ for the queue RAM's
// registered read of the head entry and makes the flush decision in B_EVAL,
// then emits one result per cycle from B_POP while the result register drains;
// an enqueue or tick that flushes nothing therefore returns to B_IDLE from
// B_EVAL, a rejected request passes through B_REJECT and a tick after shutdown
// stays in B_IDLE. The result register lets the back end load a new result in
// the same cycle that the previous one transfers. Configuration writes always
// complete at once and must only happen while the block is idle.
module request_batch_coalescer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  rbc_pkg::rbc_in_t                  req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output rbc_pkg::rbc_out_t                 rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbc_pkg::BYTES_W-1:0]       cfg_wdata
);
    import rbc_pkg::*;

    rbc_cfg_t cfg_reg, cfg_next;

    logic     cmd_valid;
    logic     cmd_ready;
    rbc_cmd_t cmd;

    // Every configuration transfer completes in its own cycle
    assign cfg_ready = 1'b1;

    // Decode the register index; drop writes beyond the register list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BATCH_COUNT: cfg_next.batch_count     = cfg_wdata[BCNT_W-1:0];
                CFG_BATCH_DELAY: cfg_next.batch_delay_ms  = cfg_wdata[DELAY_W-1:0];
                CFG_BATCH_BYTES: cfg_next.batch_max_bytes = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.batch_count     <= BATCH_COUNT_RST;
            cfg_reg.batch_delay_ms  <= BATCH_DELAY_RST;
            cfg_reg.batch_max_bytes <= BATCH_BYTES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Decode requests and hold them until the back end is free
    rbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Run queue updates, flush decisions and result transfers
    rbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
